// ===== sv/thm_pkg.sv =====
// Shared constants, controller state type and segment-width table for the
// thermistor count to temperature converter. No dependencies.
package thm_pkg;

    localparam int TABLE_DEPTH = 33;
    localparam int IDX_W       = 6;
    localparam int ADC_W       = 12;
    localparam int SUM_W       = 16;
    localparam int MAG_W       = 11;
    localparam int DIV_STEPS   = 16;
    localparam int CNT_W       = 4;
    localparam int STEP_W      = 6;

    localparam logic [IDX_W-1:0] TOP_IDX       = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] POS_SPLIT     = IDX_W'(8);
    localparam logic [MAG_W-1:0] TOP_TENTHS    = MAG_W'(1200);
    localparam logic [MAG_W-1:0] BOTTOM_TENTHS = MAG_W'(400);
    localparam logic [STEP_W-1:0] STEP_TENTHS  = STEP_W'(50);
    localparam logic [3:0]        SCALE        = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    // Segment widths in scaled counts; slots past the table read as zero.
    function automatic logic [SUM_W-1:0] seg_width(input logic [IDX_W-1:0] idx);
        logic [SUM_W-1:0] w;
        unique case (idx)
            6'd0:  w = 16'd110;
            6'd1:  w = 16'd142;
            6'd2:  w = 16'd182;
            6'd3:  w = 16'd227;
            6'd4:  w = 16'd278;
            6'd5:  w = 16'd333;
            6'd6:  w = 16'd389;
            6'd7:  w = 16'd444;
            6'd8:  w = 16'd492;
            6'd9:  w = 16'd531;
            6'd10: w = 16'd558;
            6'd11: w = 16'd570;
            6'd12: w = 16'd567;
            6'd13: w = 16'd551;
            6'd14: w = 16'd524;
            6'd15: w = 16'd488;
            6'd16: w = 16'd446;
            6'd17: w = 16'd401;
            6'd18: w = 16'd357;
            6'd19: w = 16'd315;
            6'd20: w = 16'd275;
            6'd21: w = 16'd239;
            6'd22: w = 16'd206;
            6'd23: w = 16'd178;
            6'd24: w = 16'd153;
            6'd25: w = 16'd130;
            6'd26: w = 16'd112;
            6'd27: w = 16'd96;
            6'd28: w = 16'd83;
            6'd29: w = 16'd71;
            6'd30: w = 16'd61;
            6'd31: w = 16'd53;
            6'd32: w = 16'd383;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/thermistor_adc_to_temperature.sv =====
// Thermistor count to temperature converter: table walk, serial divider, output register.
// Depends on thm_pkg.

// One input beat yields one result beat in tenths of a degree C, as magnitude
// plus sign. When the top segment already covers the count, the result is
// 120.0 without a walk; otherwise a table walk visits segments downward (one
// synchronous ROM read per cycle, at most 32 segments). A hit is followed by
// interpolation (a multiply state, a 16-step restoring divider, a finishing
// state); a walk that runs off the bottom gives -40.0. The block takes one item
// at a time; the next input beat is taken as soon as the previous result sits
// in the output register, even while that result is stalled.
module thermistor_adc_to_temperature
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [thm_pkg::ADC_W-1:0]           adc_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [thm_pkg::MAG_W-1:0]           temp_magnitude,
    output logic                                is_negative
);

    thm_pkg::state_t state_reg, state_next;

    logic [thm_pkg::IDX_W-1:0]   rom_addr;
    logic [thm_pkg::SUM_W-1:0]   rom_q_reg;

    logic [thm_pkg::SUM_W-1:0]   scaled_reg, scaled_next;
    logic [thm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [thm_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [thm_pkg::SUM_W-1:0]   div_reg, div_next;
    logic [thm_pkg::SUM_W-1:0]   num_reg, num_next;
    logic [thm_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [thm_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [thm_pkg::MAG_W-1:0]   res_mag_reg, res_mag_next;
    logic                        res_neg_reg, res_neg_next;

    logic                        out_valid_reg, out_valid_next;
    logic [thm_pkg::MAG_W-1:0]   out_mag_reg, out_mag_next;
    logic                        out_neg_reg, out_neg_next;

    logic                        accept;
    logic                        out_free;
    logic [thm_pkg::SUM_W-1:0]   walk_sum;
    logic                        walk_hit;
    logic [thm_pkg::SUM_W-1:0]   diff;
    logic [thm_pkg::SUM_W-1:0]   prod;
    logic [thm_pkg::SUM_W:0]     rem_sh;
    logic                        rem_ge;
    logic [thm_pkg::IDX_W-1:0]   seg_off;
    logic [thm_pkg::IDX_W+thm_pkg::STEP_W-1:0] offset;
    logic [thm_pkg::SUM_W-1:0]   quot;
    logic [thm_pkg::SUM_W-1:0]   val;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign walk_sum = sum_reg + rom_q_reg;
    assign walk_hit = walk_sum > scaled_reg;
    assign diff     = sum_reg - scaled_reg;
    // diff stays below the segment width, so the product fits in SUM_W bits
    assign prod     = diff * thm_pkg::SUM_W'(thm_pkg::STEP_TENTHS);
    assign rem_sh   = {rem_reg, num_reg[thm_pkg::SUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, div_reg};
    assign seg_off  = (idx_reg >= thm_pkg::POS_SPLIT) ? (idx_reg - thm_pkg::POS_SPLIT)
                                                       : idx_reg;
    assign offset   = seg_off * thm_pkg::STEP_TENTHS;
    assign quot     = (div_reg == '0) ? '0 : num_reg;
    assign val      = quot + thm_pkg::SUM_W'(offset);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            thm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = thm_pkg::ST_TOP;
                end
            end
            thm_pkg::ST_TOP:
            begin
                if (rom_q_reg >= scaled_reg)
                begin
                    state_next = thm_pkg::ST_OUT;
                end
                else
                begin
                    state_next = thm_pkg::ST_WALK;
                end
            end
            thm_pkg::ST_WALK:
            begin
                if (walk_hit)
                begin
                    state_next = thm_pkg::ST_MUL;
                end
                else if (idx_reg == '0)
                begin
                    state_next = thm_pkg::ST_OUT;
                end
            end
            thm_pkg::ST_MUL:
            begin
                state_next = thm_pkg::ST_DIV;
            end
            thm_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = thm_pkg::ST_FIN;
                end
            end
            thm_pkg::ST_FIN:
            begin
                state_next = thm_pkg::ST_OUT;
            end
            thm_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = thm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = thm_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall = (state_reg != thm_pkg::ST_IDLE);
        rom_addr = (state_reg == thm_pkg::ST_IDLE) ? thm_pkg::TOP_IDX : (idx_reg - 1'b1);
    end

    // Datapath
    always_comb
    begin
        scaled_next    = scaled_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        div_next       = div_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_mag_next   = res_mag_reg;
        res_neg_next   = res_neg_reg;
        out_mag_next   = out_mag_reg;
        out_neg_next   = out_neg_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            thm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    scaled_next = thm_pkg::SUM_W'(adc_count)
                                * thm_pkg::SUM_W'(thm_pkg::SCALE);
                    idx_next    = thm_pkg::TOP_IDX;
                end
            end
            thm_pkg::ST_TOP:
            begin
                sum_next     = rom_q_reg;
                idx_next     = idx_reg - 1'b1;
                res_mag_next = thm_pkg::TOP_TENTHS;
                res_neg_next = 1'b0;
            end
            thm_pkg::ST_WALK:
            begin
                sum_next = walk_sum;
                div_next = rom_q_reg;
                if (!walk_hit)
                begin
                    // Advance downward; fall off the bottom at -40.0
                    idx_next     = idx_reg - 1'b1;
                    res_mag_next = thm_pkg::BOTTOM_TENTHS;
                    res_neg_next = 1'b1;
                end
            end
            thm_pkg::ST_MUL:
            begin
                num_next = prod;
                rem_next = '0;
                cnt_next = thm_pkg::CNT_W'(thm_pkg::DIV_STEPS - 1);
            end
            thm_pkg::ST_DIV:
            begin
                // One restoring step per cycle; quotient shifts into num_reg
                rem_next = rem_ge ? thm_pkg::SUM_W'(rem_sh - {1'b0, div_reg})
                                  : rem_sh[thm_pkg::SUM_W-1:0];
                num_next = {num_reg[thm_pkg::SUM_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            thm_pkg::ST_FIN:
            begin
                if (idx_reg >= thm_pkg::POS_SPLIT)
                begin
                    res_mag_next = val[thm_pkg::MAG_W-1:0];
                    res_neg_next = 1'b0;
                end
                else
                begin
                    res_mag_next = (val <= thm_pkg::SUM_W'(thm_pkg::BOTTOM_TENTHS))
                        ? (thm_pkg::BOTTOM_TENTHS - val[thm_pkg::MAG_W-1:0]) : '0;
                    res_neg_next = 1'b1;
                end
            end
            thm_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mag_next   = res_mag_reg;
                    out_neg_next   = res_neg_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Segment-width ROM, registered read
    always_ff @(posedge clk)
    begin
        rom_q_reg <= thm_pkg::seg_width(rom_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= thm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg  <= scaled_next;
        sum_reg     <= sum_next;
        idx_reg     <= idx_next;
        div_reg     <= div_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        res_mag_reg <= res_mag_next;
        res_neg_reg <= res_neg_next;
        out_mag_reg <= out_mag_next;
        out_neg_reg <= out_neg_next;
    end

    assign out_valid      = out_valid_reg;
    assign temp_magnitude = out_mag_reg;
    assign is_negative    = out_neg_reg;

    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == thm_pkg::ST_TOP)
        else $error("accepted beat did not start the table walk");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == thm_pkg::ST_DIV) && (cnt_reg == '0) |=> state_reg == thm_pkg::ST_FIN)
        else $error("divider overran its step count");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_neg_reg ? (out_mag_reg <= thm_pkg::BOTTOM_TENTHS)
                                       : (out_mag_reg <= thm_pkg::TOP_TENTHS)))
        else $error("result outside temperature range");

    a_push_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_mag_reg))
        else $error("stalled result overwritten");

endmodule
